### design/ppu_pkg.sv
// Shared types and constants for the particle pool update block.
package ppu_pkg;

	localparam int POOL_SIZE = 256;
	localparam int IDX_W     = $clog2(POOL_SIZE);
	localparam int CNT_W     = $clog2(POOL_SIZE + 1);
	localparam int VAL_W     = 32;
	localparam int VAR_W     = 31;
	localparam int DRAW_W    = 16;
	localparam int FRAC_W    = 16;
	localparam int CFG_IDX_W = 2;

	// Command codes carried in the func field
	localparam logic [1:0] FUNC_EMIT = 2'd0;
	localparam logic [1:0] FUNC_TICK = 2'd1;
	localparam logic [1:0] FUNC_READ = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ROT_VAR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VELX_VAR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_VELY_VAR = 2'd2;

	typedef struct packed {
		logic [1:0]              func;
		logic signed [VAL_W-1:0] pos_x;
		logic signed [VAL_W-1:0] pos_y;
		logic signed [VAL_W-1:0] rotation_in;
		logic signed [VAL_W-1:0] vel_x;
		logic signed [VAL_W-1:0] vel_y;
		logic [VAR_W-1:0]        lifetime;
		logic signed [DRAW_W-1:0] rand_rot;
		logic signed [DRAW_W-1:0] rand_vx;
		logic signed [DRAW_W-1:0] rand_vy;
		logic [FRAC_W-1:0]       delta_time;
		logic [7:0]              read_index;
	} cmd_item_t;

	typedef struct packed {
		logic [7:0]              slot;
		logic                    alive;
		logic signed [VAL_W-1:0] out_pos_x;
		logic signed [VAL_W-1:0] out_pos_y;
		logic signed [VAL_W-1:0] out_rotation;
		logic signed [VAL_W-1:0] out_life;
		logic [CNT_W-1:0]        live_count;
	} rsp_item_t;

	// One pool entry as kept in the particle memory
	typedef struct packed {
		logic [VAL_W-1:0] pos_x;
		logic [VAL_W-1:0] pos_y;
		logic [VAL_W-1:0] rotation;
		logic [VAL_W-1:0] vel_x;
		logic [VAL_W-1:0] vel_y;
		logic [VAL_W-1:0] life;
	} particle_t;

endpackage

### design/ppu_cmd_if.sv
// Command channel: valid/ready handshake carrying one command item.
interface ppu_cmd_if;
	logic               valid;
	logic               ready;
	ppu_pkg::cmd_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### design/ppu_rsp_if.sv
// Response channel: valid/ready handshake carrying one result item.
interface ppu_rsp_if;
	logic               valid;
	logic               ready;
	ppu_pkg::rsp_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### design/ppu_mul.sv
// Shared signed multiplier with registered Q16.16 rescale of the product.
module ppu_mul (
	input  logic                              clk,
	input  logic signed [ppu_pkg::VAL_W-1:0]  a,
	input  logic signed [ppu_pkg::FRAC_W:0]   b,
	output logic [ppu_pkg::VAL_W-1:0]         prod_q
);

	localparam int PROD_W = ppu_pkg::VAL_W + ppu_pkg::FRAC_W + 1;

	logic signed [PROD_W-1:0] prod;

	// Dropping the low fraction bits of a two's complement product floors it
	assign prod = PROD_W'(a) * PROD_W'(b);

	always_ff @(posedge clk) begin
		prod_q <= prod[ppu_pkg::FRAC_W +: ppu_pkg::VAL_W];
	end

endmodule

### design/particle_pool_update.sv
// Particle pool top level: command sequencer, particle memory and shared multiplier.
// Emit steps through rotation, x velocity, y velocity and write states; read waits for a
//   registered memory read; tick scans every slot, retiring or moving each live one.
// Throughput: one command at a time; the single multiplier and the one read/one write
//   port of the particle memory set the tick sweep length; a held result stalls intake.
// Reset clears flags, live count and variations and sets the emit pointer to the last slot; memory is not cleared.
module particle_pool_update (
	input  logic                                clk,
	input  logic                                arst_n,
	ppu_cmd_if.sink                             cmd,
	ppu_rsp_if.source                           rsp,
	input  logic                                cfg_wr_en,
	input  logic [ppu_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ppu_pkg::VAR_W-1:0]           cfg_data
);

	localparam int IDX_W = ppu_pkg::IDX_W;
	localparam int CNT_W = ppu_pkg::CNT_W;
	localparam int VAL_W = ppu_pkg::VAL_W;
	localparam int FRAC_W = ppu_pkg::FRAC_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ppu_pkg::POOL_SIZE - 1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_E_ROT,
		S_E_VX,
		S_E_VY,
		S_E_WR,
		S_R_DATA,
		S_T_SCAN,
		S_T_LIFE,
		S_T_MY,
		S_T_WR,
		S_DONE
	} state_t;

	state_t                 state_q;
	ppu_pkg::cmd_item_t     cmd_q;
	logic [IDX_W-1:0]       idx_q;
	logic [IDX_W-1:0]       emit_ptr_q;
	logic [CNT_W-1:0]       count_q;
	logic [ppu_pkg::POOL_SIZE-1:0] flags_q;
	logic [ppu_pkg::VAR_W-1:0] rot_var_q;
	logic [ppu_pkg::VAR_W-1:0] velx_var_q;
	logic [ppu_pkg::VAR_W-1:0] vely_var_q;
	logic [VAL_W-1:0]       acc0_q;
	logic [VAL_W-1:0]       acc1_q;
	logic [VAL_W-1:0]       life_q;
	ppu_pkg::rsp_item_t     res_q;
	ppu_pkg::rsp_item_t     res_out;
	logic                   rsp_valid_q;
	ppu_pkg::rsp_item_t     rsp_data_q;

	// Particle memory: one write and one registered read a cycle
	ppu_pkg::particle_t     pool_mem [ppu_pkg::POOL_SIZE];
	ppu_pkg::particle_t     rd_data_q;
	logic                   rd_en;
	logic [IDX_W-1:0]       rd_addr;
	logic                   wr_en;
	logic [IDX_W-1:0]       wr_addr;
	ppu_pkg::particle_t     wr_data;

	// Shared multiplier and the adder behind it
	logic signed [VAL_W-1:0]  mul_a;
	logic signed [FRAC_W:0]   mul_b;
	logic [VAL_W-1:0]         mul_prod;
	logic [VAL_W-1:0]         add_base;
	logic [VAL_W-1:0]         add_res;
	logic [VAL_W-1:0]         life_new;
	logic                     life_out;
	logic                     cmd_take;
	logic                     rsp_free;

	ppu_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (mul_prod)
	);

	assign cmd.ready = (state_q == S_IDLE);
	assign cmd_take  = cmd.valid && (state_q == S_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;
	assign rsp_free  = !rsp_valid_q || rsp.ready;

	assign add_res  = add_base + mul_prod;
	assign life_new = rd_data_q.life - VAL_W'(cmd_q.delta_time);
	// Retire when the remaining life is zero or negative
	assign life_out = life_new[VAL_W-1] || (life_new == '0);

	// Finished result with the live count after this item
	always_comb begin
		res_out            = res_q;
		res_out.live_count = count_q;
	end

	// Operand and base selection for the shared unit
	always_comb begin
		mul_a    = '0;
		mul_b    = '0;
		add_base = '0;
		unique case (state_q)
			S_E_ROT: begin
				mul_a = signed'({1'b0, rot_var_q});
				mul_b = signed'({cmd_q.rand_rot[FRAC_W-1], cmd_q.rand_rot});
			end
			S_E_VX: begin
				mul_a    = signed'({1'b0, velx_var_q});
				mul_b    = signed'({cmd_q.rand_vx[FRAC_W-1], cmd_q.rand_vx});
				add_base = cmd_q.rotation_in;
			end
			S_E_VY: begin
				mul_a    = signed'({1'b0, vely_var_q});
				mul_b    = signed'({cmd_q.rand_vy[FRAC_W-1], cmd_q.rand_vy});
				add_base = cmd_q.vel_x;
			end
			S_E_WR: begin
				add_base = cmd_q.vel_y;
			end
			S_T_LIFE: begin
				mul_a = signed'(rd_data_q.vel_x);
				mul_b = signed'({1'b0, cmd_q.delta_time});
			end
			S_T_MY: begin
				mul_a    = signed'(rd_data_q.vel_y);
				mul_b    = signed'({1'b0, cmd_q.delta_time});
				add_base = rd_data_q.pos_x;
			end
			S_T_WR: begin
				add_base = rd_data_q.pos_y;
			end
			default: begin
			end
		endcase
	end

	// Memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_q;
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = rd_data_q;
		unique case (state_q)
			S_IDLE: begin
				rd_en   = cmd_take && (cmd.data.func == ppu_pkg::FUNC_READ);
				rd_addr = cmd.data.read_index[IDX_W-1:0];
			end
			S_T_SCAN: begin
				rd_en = flags_q[idx_q];
			end
			S_E_WR: begin
				wr_en   = 1'b1;
				wr_addr = emit_ptr_q;
				wr_data = '{pos_x: cmd_q.pos_x, pos_y: cmd_q.pos_y, rotation: acc0_q,
					vel_x: acc1_q, vel_y: add_res, life: VAL_W'(cmd_q.lifetime)};
			end
			S_T_LIFE: begin
				// Retire: keep the stores, record the last life value
				wr_en        = life_out;
				wr_data.life = life_new;
			end
			S_T_WR: begin
				wr_en         = 1'b1;
				wr_data.pos_x = acc0_q;
				wr_data.pos_y = add_res;
				wr_data.life  = life_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			pool_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= pool_mem[rd_addr];
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_var_q  <= '0;
			velx_var_q <= '0;
			vely_var_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				ppu_pkg::CFG_ROT_VAR:  rot_var_q  <= cfg_data;
				ppu_pkg::CFG_VELX_VAR: velx_var_q <= cfg_data;
				ppu_pkg::CFG_VELY_VAR: vely_var_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Sequencer, pool state and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cmd_q       <= '0;
			res_q       <= '0;
			idx_q       <= '0;
			emit_ptr_q  <= LAST_IDX;
			count_q     <= '0;
			flags_q     <= '0;
			acc0_q      <= '0;
			acc1_q      <= '0;
			life_q      <= '0;
			rsp_valid_q <= 1'b0;
			rsp_data_q  <= '0;
		end else begin
			// Drop the result once taken, unless a new one replaces it now
			if (rsp_valid_q && rsp.ready && (state_q != S_DONE)) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_take) begin
						cmd_q <= cmd.data;
						res_q <= '0;
						idx_q <= (cmd.data.func == ppu_pkg::FUNC_READ)
							? cmd.data.read_index[IDX_W-1:0] : '0;
						unique case (cmd.data.func)
							ppu_pkg::FUNC_EMIT: state_q <= S_E_ROT;
							ppu_pkg::FUNC_TICK: state_q <= S_T_SCAN;
							ppu_pkg::FUNC_READ: state_q <= S_R_DATA;
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_E_ROT: begin
					state_q <= S_E_VX;
				end
				S_E_VX: begin
					acc0_q  <= add_res;
					state_q <= S_E_VY;
				end
				S_E_VY: begin
					acc1_q  <= add_res;
					state_q <= S_E_WR;
				end
				S_E_WR: begin
					// Overwriting a live slot does not grow the count
					if (!flags_q[emit_ptr_q]) begin
						count_q <= count_q + CNT_W'(1);
					end
					flags_q[emit_ptr_q] <= 1'b1;
					res_q.slot          <= 8'(emit_ptr_q);
					res_q.alive         <= 1'b1;
					res_q.out_pos_x     <= cmd_q.pos_x;
					res_q.out_pos_y     <= cmd_q.pos_y;
					res_q.out_rotation  <= acc0_q;
					res_q.out_life      <= VAL_W'(cmd_q.lifetime);
					emit_ptr_q          <= (emit_ptr_q == '0) ? LAST_IDX
						: emit_ptr_q - IDX_W'(1);
					state_q             <= S_DONE;
				end
				S_R_DATA: begin
					res_q.slot         <= 8'(idx_q);
					res_q.alive        <= flags_q[idx_q];
					res_q.out_pos_x    <= rd_data_q.pos_x;
					res_q.out_pos_y    <= rd_data_q.pos_y;
					res_q.out_rotation <= rd_data_q.rotation;
					res_q.out_life     <= rd_data_q.life;
					state_q            <= S_DONE;
				end
				S_T_SCAN: begin
					if (flags_q[idx_q]) begin
						state_q <= S_T_LIFE;
					end else if (idx_q == LAST_IDX) begin
						state_q <= S_DONE;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				S_T_LIFE: begin
					life_q <= life_new;
					if (life_out) begin
						flags_q[idx_q] <= 1'b0;
						count_q        <= count_q - CNT_W'(1);
						if (idx_q == LAST_IDX) begin
							state_q <= S_DONE;
						end else begin
							idx_q   <= idx_q + IDX_W'(1);
							state_q <= S_T_SCAN;
						end
					end else begin
						state_q <= S_T_MY;
					end
				end
				S_T_MY: begin
					acc0_q  <= add_res;
					state_q <= S_T_WR;
				end
				S_T_WR: begin
					if (idx_q == LAST_IDX) begin
						state_q <= S_DONE;
					end else begin
						idx_q   <= idx_q + IDX_W'(1);
						state_q <= S_T_SCAN;
					end
				end
				S_DONE: begin
					// Hold until the output register is free
					if (rsp_free) begin
						rsp_valid_q <= 1'b1;
						rsp_data_q  <= res_out;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### design/ppu_checker.sv
// Port-level checker for the particle pool update block, bound to the top level.
module ppu_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      cmd_valid,
	input logic                      cmd_ready,
	input logic                      rsp_valid,
	input logic                      rsp_ready,
	input ppu_pkg::rsp_item_t        rsp_data
);

	// The live count can never exceed the pool
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_data.live_count <= ppu_pkg::CNT_W'(ppu_pkg::POOL_SIZE)))
		else $error("live count beyond pool size");

	// A command in progress blocks the next one
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_ready) |=> !cmd_ready)
		else $error("ready high right after accept");

	// A new result appears only as a command finishes, never from idle
	a_rsp_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(!cmd_ready))
		else $error("result raised while idle");

	// Stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
		else $error("stalled result changed");

endmodule

bind particle_pool_update ppu_checker u_ppu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd.valid),
	.cmd_ready (cmd.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

### sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for particle_pool_update: emit, tick and read traffic against a predictor.
module tb_top;

	localparam int POOL_SIZE = ppu_pkg::POOL_SIZE;
	localparam int VAL_W     = ppu_pkg::VAL_W;
	localparam int VAR_W     = ppu_pkg::VAR_W;
	localparam int DRAW_W    = ppu_pkg::DRAW_W;
	localparam int FRAC_W    = ppu_pkg::FRAC_W;
	localparam int CNT_W     = ppu_pkg::CNT_W;
	localparam int CFG_IDX_W = ppu_pkg::CFG_IDX_W;

	typedef ppu_pkg::cmd_item_t cmd_item_t;
	typedef ppu_pkg::rsp_item_t rsp_item_t;
	typedef ppu_pkg::particle_t particle_t;

	// Func code that the block must ignore: no state change, tick-shaped result
	localparam logic [1:0] FUNC_IDLE = 2'd3;

	localparam int CLK_HALF    = 6;
	localparam int RESET_CYCLES = 12;
	// Keep a wide margin over both the slowest tick sweep and a result hold-off
	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;
	localparam int IDLE_PCT    = 36;
	localparam logic [VAR_W-1:0] VAR_MAX = '1;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [VAR_W-1:0]     cfg_data;

	ppu_cmd_if cmd_ch ();
	ppu_rsp_if rsp_ch ();

	particle_pool_update uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.rsp       (rsp_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Shadow copy of the pool, the emit pointer and the variation registers
	particle_t        pool_mem     [POOL_SIZE];
	bit               pool_live    [POOL_SIZE];
	bit               pool_written [POOL_SIZE];
	int unsigned      emit_slot;
	int unsigned      live_total;
	logic [VAR_W-1:0] rot_var;
	logic [VAR_W-1:0] velx_var;
	logic [VAR_W-1:0] vely_var;

	// Results still owed by the block, oldest first
	rsp_item_t   pending_rsp [$];
	int unsigned mismatches;
	int unsigned idle_cycles;
	int unsigned hold_left;
	bit          no_idle;

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Base plus floor(variation * draw / 2^16), wrapped to 32 bits
	function automatic logic [VAL_W-1:0] add_jitter(logic [VAL_W-1:0] base,
		logic [VAR_W-1:0] scale, logic [DRAW_W-1:0] draw);
		longint prod;
		prod = longint'({33'd0, scale}) * longint'($signed(draw));
		prod = prod >>> FRAC_W;
		return base + prod[VAL_W-1:0];
	endfunction

	// Position plus floor(velocity * dt / 2^16), wrapped to 32 bits
	function automatic logic [VAL_W-1:0] advance(logic [VAL_W-1:0] posv,
		logic [VAL_W-1:0] vel, logic [FRAC_W-1:0] dt);
		longint step;
		step = longint'($signed(vel)) * longint'({48'd0, dt});
		step = step >>> FRAC_W;
		return posv + step[VAL_W-1:0];
	endfunction

	function automatic rsp_item_t slot_view(int unsigned s);
		rsp_item_t r;
		r              = '0;
		r.slot         = s[7:0];
		r.alive        = pool_live[s];
		r.out_pos_x    = pool_mem[s].pos_x;
		r.out_pos_y    = pool_mem[s].pos_y;
		r.out_rotation = pool_mem[s].rotation;
		r.out_life     = pool_mem[s].life;
		return r;
	endfunction

	// Apply one command to the shadow pool and return the result it owes
	function automatic rsp_item_t pool_response(cmd_item_t c);
		rsp_item_t   r;
		int unsigned s;
		r = '0;
		case (c.func)
			ppu_pkg::FUNC_EMIT: begin
				s = emit_slot;
				// overwriting a live slot leaves the count alone
				if (!pool_live[s])
					live_total++;
				pool_live[s]             = 1'b1;
				pool_written[s]          = 1'b1;
				pool_mem[s].pos_x        = c.pos_x;
				pool_mem[s].pos_y        = c.pos_y;
				pool_mem[s].rotation     = add_jitter(c.rotation_in, rot_var, c.rand_rot);
				pool_mem[s].vel_x        = add_jitter(c.vel_x, velx_var, c.rand_vx);
				pool_mem[s].vel_y        = add_jitter(c.vel_y, vely_var, c.rand_vy);
				pool_mem[s].life         = {1'b0, c.lifetime};
				r                        = slot_view(s);
				emit_slot                = (s == 0) ? POOL_SIZE - 1 : s - 1;
			end
			ppu_pkg::FUNC_TICK: begin
				for (int i = 0; i < POOL_SIZE; i++) begin
					if (pool_live[i]) begin
						pool_mem[i].life = pool_mem[i].life - {16'd0, c.delta_time};
						// retire at zero or below; a retired entry keeps its stores
						if ($signed(pool_mem[i].life) <= 0) begin
							pool_live[i] = 1'b0;
							live_total--;
						end else begin
							pool_mem[i].pos_x = advance(pool_mem[i].pos_x,
								pool_mem[i].vel_x, c.delta_time);
							pool_mem[i].pos_y = advance(pool_mem[i].pos_y,
								pool_mem[i].vel_y, c.delta_time);
						end
					end
				end
			end
			ppu_pkg::FUNC_READ: r = slot_view(c.read_index);
			default: ;
		endcase
		r.live_count = CNT_W'(live_total);
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic cmd_item_t blank_cmd(logic [1:0] f);
		cmd_item_t c;
		c      = '0;
		c.func = f;
		return c;
	endfunction

	function automatic cmd_item_t read_of(logic [7:0] idx);
		cmd_item_t c;
		c            = blank_cmd(ppu_pkg::FUNC_READ);
		c.read_index = idx;
		return c;
	endfunction

	function automatic cmd_item_t tick_of(logic [FRAC_W-1:0] dt);
		cmd_item_t c;
		c            = blank_cmd(ppu_pkg::FUNC_TICK);
		c.delta_time = dt;
		return c;
	endfunction

	// Reads only go to slots that an emit has filled
	function automatic logic [7:0] pick_read_index();
		logic [7:0] idx;
		do
			idx = 8'($urandom);
		while (!pool_written[idx]);
		return idx;
	endfunction

	function automatic logic [1:0] random_func();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return ppu_pkg::FUNC_EMIT;
		else if (r < 70)
			return ppu_pkg::FUNC_TICK;
		else if (r < 98)
			return ppu_pkg::FUNC_READ;
		return FUNC_IDLE;
	endfunction

	function automatic cmd_item_t random_cmd(logic [1:0] f);
		cmd_item_t c;
		c.func        = f;
		c.pos_x       = $urandom;
		c.pos_y       = $urandom;
		c.rotation_in = $urandom;
		// mostly modest speeds so particles drift; sometimes anything goes
		if ($urandom_range(0, 3) == 0) begin
			c.vel_x = $urandom;
			c.vel_y = $urandom;
		end else begin
			c.vel_x = $urandom_range(0, 32'h0028_0000) - 32'h0014_0000;
			c.vel_y = $urandom_range(0, 32'h0028_0000) - 32'h0014_0000;
		end
		// lifetimes of a few seconds so ticks retire particles at a steady pace
		case ($urandom_range(0, 9))
			0:       c.lifetime = '0;
			1:       c.lifetime = VAR_W'($urandom);
			default: c.lifetime = VAR_W'($urandom_range(1, 32'h0008_0000));
		endcase
		c.rand_rot = DRAW_W'($urandom);
		c.rand_vx  = DRAW_W'($urandom);
		c.rand_vy  = DRAW_W'($urandom);
		case ($urandom_range(0, 9))
			0:       c.delta_time = '0;
			1:       c.delta_time = '1;
			default: c.delta_time = FRAC_W'($urandom);
		endcase
		c.read_index = (f == ppu_pkg::FUNC_READ) ? pick_read_index() : 8'($urandom);
		return c;
	endfunction

	// Offer one item, hold it until accepted, then log what it owes.
	// Valid stays high afterwards so the next item can follow with no gap.
	task automatic send_cmd(cmd_item_t c);
		if (!no_idle) begin
			while ($urandom_range(0, 99) < IDLE_PCT) begin
				cmd_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.data  <= c;
		do
			@(posedge clk);
		while (cmd_ch.ready !== 1'b1);
		pending_rsp.push_back(pool_response(c));
	endtask

	// Drop valid and wait until every owed result is back
	task automatic drain();
		cmd_ch.valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [VAR_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	// Block must be idle when this is called
	task automatic load_variations(logic [VAR_W-1:0] rv, logic [VAR_W-1:0] vx,
		logic [VAR_W-1:0] vy);
		write_reg(ppu_pkg::CFG_ROT_VAR, rv);
		write_reg(ppu_pkg::CFG_VELX_VAR, vx);
		write_reg(ppu_pkg::CFG_VELY_VAR, vy);
		cfg_wr_en <= 1'b0;
		rot_var  = rv;
		velx_var = vx;
		vely_var = vy;
	endtask

	task automatic report_mismatch(string what, logic [VAL_W-1:0] got,
		logic [VAL_W-1:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
		mismatches++;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Field extremes, zero lifetime, life landing exactly on zero, position
	// wrap, zero and full frame times, reads of retired slots, unused func
	task automatic test_directed();
		cmd_item_t c;
		load_variations(VAR_MAX, '0, 31'h0001_8000);

		// slot 255: every field at an extreme; rotation and y velocity wrap
		c             = blank_cmd(ppu_pkg::FUNC_EMIT);
		c.pos_x       = 32'h7FFF_FFFF;
		c.pos_y       = 32'h8000_0000;
		c.rotation_in = 32'h8000_0000;
		c.vel_x       = 32'h7FFF_FFFF;
		c.vel_y       = 32'h8000_0000;
		c.lifetime    = '1;
		c.rand_rot    = 16'sh8000;
		c.rand_vx     = 16'sh7FFF;
		c.rand_vy     = 16'sh8000;
		send_cmd(c);
		// slot 254: zero lifetime, all else zero
		send_cmd(blank_cmd(ppu_pkg::FUNC_EMIT));
		// slot 253: life hits exactly zero on a full-length frame
		c             = blank_cmd(ppu_pkg::FUNC_EMIT);
		c.pos_x       = 32'h7FFF_0000;
		c.vel_x       = 32'h0002_0000;
		c.lifetime    = 31'h0000_FFFF;
		c.rand_rot    = 16'sh7FFF;
		c.rand_vy     = 16'sh7FFF;
		send_cmd(c);
		// slot 252: survives a few frames, moves backward
		c             = blank_cmd(ppu_pkg::FUNC_EMIT);
		c.pos_y       = 32'h8000_0100;
		c.vel_x       = 32'hFFFF_0000;
		c.vel_y       = 32'hFFF0_0000;
		c.lifetime    = 31'h0002_0000;
		c.rand_vy     = 16'sh8000;
		send_cmd(c);
		send_cmd(read_of(8'd255));
		send_cmd(read_of(8'd254));
		send_cmd(read_of(8'd253));

		send_cmd(tick_of('1));
		send_cmd(read_of(8'd254));
		send_cmd(read_of(8'd253));
		send_cmd(read_of(8'd255));
		send_cmd(read_of(8'd252));
		send_cmd(tick_of('0));
		send_cmd(tick_of('1));

		c             = random_cmd(FUNC_IDLE);
		send_cmd(c);
		// slot 251: one tick of life; a frame of one unit retires it
		c             = blank_cmd(ppu_pkg::FUNC_EMIT);
		c.lifetime    = 31'd1;
		send_cmd(c);
		send_cmd(read_of(8'd251));
		send_cmd(tick_of(16'd1));
		send_cmd(read_of(8'd251));
		send_cmd(read_of(8'd252));
	endtask

	// Fill the whole pool with long-lived particles, run past the wrap so
	// emits land on live slots, then tick and read a full house
	task automatic test_pool_wrap();
		cmd_item_t c;
		drain();
		load_variations(VAR_MAX, VAR_MAX, VAR_MAX);
		for (int n = 0; n < POOL_SIZE + 8; n++) begin
			c          = random_cmd(ppu_pkg::FUNC_EMIT);
			c.lifetime = VAR_W'($urandom_range(32'h0010_0000, 32'h7FFF_FFFF));
			send_cmd(c);
		end
		send_cmd(random_cmd(ppu_pkg::FUNC_TICK));
		for (int n = 0; n < 30; n++)
			send_cmd(random_cmd(ppu_pkg::FUNC_READ));
	endtask

	task automatic test_random_mix(logic [VAR_W-1:0] rv, logic [VAR_W-1:0] vx,
		logic [VAR_W-1:0] vy, int count);
		drain();
		load_variations(rv, vx, vy);
		for (int n = 0; n < count; n++)
			send_cmd(random_cmd(random_func()));
	endtask

	// Both sides run flat out
	task automatic test_no_idle(int count);
		no_idle = 1'b1;
		for (int n = 0; n < count; n++)
			send_cmd(random_cmd(random_func()));
		no_idle = 1'b0;
	endtask

	// Hold results back for a long stretch while items keep coming
	task automatic test_backpressure(int count);
		hold_left = HOLD_CYCLES;
		for (int n = 0; n < count; n++)
			send_cmd(random_cmd(random_func()));
	endtask

	// ------------------------------------------------------------------
	// Result side: ready pattern, checker, watchdog
	// ------------------------------------------------------------------

	// Hold off while a hold-off is counting, else idle at random
	always @(posedge clk) begin
		if (hold_left > 0) begin
			rsp_ch.ready <= 1'b0;
			hold_left = hold_left - 1;
		end else if (no_idle) begin
			rsp_ch.ready <= 1'b1;
		end else begin
			rsp_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// Compare each accepted result with the oldest one owed
	always @(posedge clk) begin : check_rsp
		rsp_item_t want;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (pending_rsp.size() == 0) begin
				report_mismatch("unexpected result, slot", VAL_W'(rsp_ch.data.slot), '0);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp_ch.data.slot !== want.slot)
					report_mismatch("slot", VAL_W'(rsp_ch.data.slot), VAL_W'(want.slot));
				if (rsp_ch.data.alive !== want.alive)
					report_mismatch("alive", VAL_W'(rsp_ch.data.alive), VAL_W'(want.alive));
				if (rsp_ch.data.out_pos_x !== want.out_pos_x)
					report_mismatch("out_pos_x", rsp_ch.data.out_pos_x, want.out_pos_x);
				if (rsp_ch.data.out_pos_y !== want.out_pos_y)
					report_mismatch("out_pos_y", rsp_ch.data.out_pos_y, want.out_pos_y);
				if (rsp_ch.data.out_rotation !== want.out_rotation)
					report_mismatch("out_rotation", rsp_ch.data.out_rotation,
						want.out_rotation);
				if (rsp_ch.data.out_life !== want.out_life)
					report_mismatch("out_life", rsp_ch.data.out_life, want.out_life);
				if (rsp_ch.data.live_count !== want.live_count)
					report_mismatch("live_count", VAL_W'(rsp_ch.data.live_count),
						VAL_W'(want.live_count));
			end
		end
	end

	// Count cycles in which neither channel moves an item
	always @(posedge clk) begin
		if (!arst_n || (cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1) ||
			(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= STALL_LIMIT);
		$display("timeout: no item moved for %0d cycles", STALL_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_index     = ppu_pkg::CFG_ROT_VAR;
		cfg_data      = '0;
		cmd_ch.valid  = 1'b0;
		cmd_ch.data   = '0;
		rsp_ch.ready  = 1'b0;
		no_idle       = 1'b0;
		hold_left     = 0;
		mismatches    = 0;
		emit_slot     = POOL_SIZE - 1;
		live_total    = 0;
		rot_var       = '0;
		velx_var      = '0;
		vely_var      = '0;
		for (int i = 0; i < POOL_SIZE; i++) begin
			pool_live[i]    = 1'b0;
			pool_written[i] = 1'b0;
			pool_mem[i]     = '0;
		end

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_pool_wrap();
		test_random_mix('0, '0, '0, 200);
		test_random_mix(VAR_W'($urandom), VAR_W'($urandom), VAR_W'($urandom), 200);
		test_random_mix(VAR_MAX, '0, VAR_MAX, 200);
		test_random_mix(31'h0000_8000, VAR_MAX, 31'h0001_0000, 200);
		test_no_idle(150);
		test_backpressure(40);

		// let any stray result show up before the verdict
		drain();
		repeat (30) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
